// File: rtl/rzsm_pkg.sv
// Shared types, constants and the quarter-wave sine table for the Z rotation block.
`default_nettype none

package rzsm_pkg;

    localparam int unsigned MagW         = 16;
    localparam int unsigned ColorW       = 8;
    localparam int unsigned CoefW        = 11;
    localparam int unsigned AngleW       = 7;
    localparam int unsigned ReducedW     = 5;
    localparam int unsigned QShift       = 10;
    localparam int unsigned ProdW        = MagW + CoefW;
    localparam int unsigned DataW        = 64;

    localparam int unsigned AngleSteps   = 72;
    localparam int unsigned HalfSteps    = 36;
    localparam int unsigned ThreeQSteps  = 54;
    localparam int unsigned QuarterSteps = 18;
    localparam int unsigned QOne         = 1024;

    typedef logic [CoefW-1:0] coef_q_t;

    // Sine and cosine of the configured angle, reduced to the first quadrant.
    typedef struct packed {
        coef_q_t sin_q;
        coef_q_t cos_q;
        logic    s_neg;
        logic    c_neg;
    } rot_coef_t;

    // One point in sign-magnitude form, with its colour tag.
    typedef struct packed {
        logic [MagW-1:0]   x_mag;
        logic              x_neg;
        logic [MagW-1:0]   y_mag;
        logic              y_neg;
        logic [MagW-1:0]   z_mag;
        logic              z_neg;
        logic [ColorW-1:0] color;
    } point_t;

    // One sign-magnitude value.
    typedef struct packed {
        logic [MagW-1:0] mag;
        logic            neg;
    } sm_t;

    // The four product terms of the rotation, plus the pass-through fields.
    typedef struct packed {
        sm_t               xc;
        sm_t               ys;
        sm_t               xs;
        sm_t               yc;
        sm_t               z;
        logic [ColorW-1:0] color;
    } terms_t;

    // Q10 sine for reduced steps of 5 degrees, 0 to 90 degrees.
    function automatic coef_q_t quarter_wave(input logic [ReducedW-1:0] r);
        coef_q_t v;
        unique case (r)
            5'd0:    v = 11'd0;
            5'd1:    v = 11'd89;
            5'd2:    v = 11'd178;
            5'd3:    v = 11'd265;
            5'd4:    v = 11'd350;
            5'd5:    v = 11'd433;
            5'd6:    v = 11'd512;
            5'd7:    v = 11'd587;
            5'd8:    v = 11'd658;
            5'd9:    v = 11'd724;
            5'd10:   v = 11'd784;
            5'd11:   v = 11'd839;
            5'd12:   v = 11'd887;
            5'd13:   v = 11'd928;
            5'd14:   v = 11'd962;
            5'd15:   v = 11'd989;
            5'd16:   v = 11'd1008;
            5'd17:   v = 11'd1020;
            5'd18:   v = 11'd1024;
            default: v = 11'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/rzsm_coef.sv
// Angle register: reduces the written angle to a quadrant and holds sine and cosine.
`default_nettype none

module rzsm_coef (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [rzsm_pkg::AngleW-1:0]  cfg_data,
    output rzsm_pkg::rot_coef_t               coef
);
    import rzsm_pkg::*;

    rot_coef_t               coef_reg;
    rot_coef_t               coef_next;
    logic [AngleW-1:0]       angle_wrapped;
    logic [AngleW-1:0]       reduced;
    logic [ReducedW-1:0]     r;
    logic                    s_neg;
    logic                    c_neg;

    assign cfg_ready = 1'b1;

    // Fold the angle into one turn, then into the first quadrant.
    always_comb begin
        if (cfg_data >= AngleW'(AngleSteps)) begin
            angle_wrapped = cfg_data - AngleW'(AngleSteps);
        end else begin
            angle_wrapped = cfg_data;
        end
        priority if (angle_wrapped >= AngleW'(ThreeQSteps)) begin
            s_neg   = 1'b1;
            c_neg   = 1'b0;
            reduced = AngleW'(AngleSteps) - angle_wrapped;
        end else if (angle_wrapped >= AngleW'(HalfSteps)) begin
            s_neg   = 1'b1;
            c_neg   = 1'b1;
            reduced = angle_wrapped - AngleW'(HalfSteps);
        end else if (angle_wrapped > AngleW'(QuarterSteps)) begin
            s_neg   = 1'b0;
            c_neg   = 1'b1;
            reduced = AngleW'(HalfSteps) - angle_wrapped;
        end else begin
            s_neg   = 1'b0;
            c_neg   = 1'b0;
            reduced = angle_wrapped;
        end
        r = reduced[ReducedW-1:0];
        coef_next.sin_q = quarter_wave(r);
        coef_next.cos_q = quarter_wave(ReducedW'(QuarterSteps) - r);
        coef_next.s_neg = s_neg;
        coef_next.c_neg = c_neg;
    end

    // Coefficients are captured on each write; reset gives angle zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg.sin_q <= '0;
            coef_reg.cos_q <= CoefW'(QOne);
            coef_reg.s_neg <= 1'b0;
            coef_reg.c_neg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

    // Any quarter-wave pair sums to at least one in Q10.
    a_coef_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        (CoefW + 1)'(coef_reg.sin_q) + (CoefW + 1)'(coef_reg.cos_q) >= (CoefW + 1)'(QOne))
        else $error("sine and cosine too small");

    // Neither coefficient exceeds one.
    a_coef_range: assert property (@(posedge aclk) disable iff (!aresetn)
        coef_reg.sin_q <= CoefW'(QOne) && coef_reg.cos_q <= CoefW'(QOne))
        else $error("coefficient above one");

    // A write of angle zero gives the identity rotation.
    a_zero_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && cfg_data == '0) |=>
        (coef_reg.sin_q == '0 && coef_reg.cos_q == CoefW'(QOne)
         && !coef_reg.s_neg && !coef_reg.c_neg))
        else $error("angle zero is not identity");

endmodule

`default_nettype wire

// File: rtl/rzsm_mult.sv
// Product stage: four Q10 products with their signs, registered.
`default_nettype none

module rzsm_mult (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire rzsm_pkg::rot_coef_t  coef,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rzsm_pkg::point_t     in_pt,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rzsm_pkg::terms_t          out_terms
);
    import rzsm_pkg::*;

    logic             valid_reg;
    terms_t           terms_reg;
    terms_t           terms_next;
    logic [ProdW-1:0] p_xc;
    logic [ProdW-1:0] p_ys;
    logic [ProdW-1:0] p_xs;
    logic [ProdW-1:0] p_yc;

    assign in_ready = !valid_reg || out_ready;

    // Products truncated by the Q10 shift; the sign of each is the XOR of its operands, inverted for the y-sine term.
    always_comb begin
        p_xc = ProdW'(in_pt.x_mag) * ProdW'(coef.cos_q);
        p_ys = ProdW'(in_pt.y_mag) * ProdW'(coef.sin_q);
        p_xs = ProdW'(in_pt.x_mag) * ProdW'(coef.sin_q);
        p_yc = ProdW'(in_pt.y_mag) * ProdW'(coef.cos_q);
        terms_next.xc.mag = p_xc[QShift+MagW-1:QShift];
        terms_next.xc.neg = coef.c_neg ^ in_pt.x_neg;
        terms_next.ys.mag = p_ys[QShift+MagW-1:QShift];
        terms_next.ys.neg = ~(coef.s_neg ^ in_pt.y_neg);
        terms_next.xs.mag = p_xs[QShift+MagW-1:QShift];
        terms_next.xs.neg = coef.s_neg ^ in_pt.x_neg;
        terms_next.yc.mag = p_yc[QShift+MagW-1:QShift];
        terms_next.yc.neg = coef.c_neg ^ in_pt.y_neg;
        terms_next.z.mag  = in_pt.z_mag;
        terms_next.z.neg  = in_pt.z_neg;
        terms_next.color  = in_pt.color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            terms_reg <= terms_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_terms = terms_reg;

endmodule

`default_nettype wire

// File: rtl/rzsm_combine.sv
// Sum stage: sign-magnitude addition of the term pairs into the output register.
`default_nettype none

module rzsm_combine (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rzsm_pkg::terms_t     in_terms,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rzsm_pkg::point_t          out_pt
);
    import rzsm_pkg::*;

    logic   valid_reg;
    point_t pt_reg;
    point_t pt_next;
    sm_t    rx;
    sm_t    ry;

    // Equal signs add and wrap; otherwise the larger keeps its sign, ties keep the first.
    function automatic sm_t sm_add(input sm_t a, input sm_t b);
        sm_t o;
        if (a.neg == b.neg) begin
            o.neg = a.neg;
            o.mag = a.mag + b.mag;
        end else if (a.mag >= b.mag) begin
            o.neg = a.neg;
            o.mag = a.mag - b.mag;
        end else begin
            o.neg = b.neg;
            o.mag = b.mag - a.mag;
        end
        return o;
    endfunction

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        rx = sm_add(in_terms.xc, in_terms.ys);
        ry = sm_add(in_terms.xs, in_terms.yc);
        pt_next.x_mag = rx.mag;
        pt_next.x_neg = rx.neg;
        pt_next.y_mag = ry.mag;
        pt_next.y_neg = ry.neg;
        pt_next.z_mag = in_terms.z.mag;
        pt_next.z_neg = in_terms.z.neg;
        pt_next.color = in_terms.color;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pt_reg <= pt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pt    = pt_reg;

    // A taken request always shows up in the output register next cycle.
    a_take_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> valid_reg)
        else $error("accepted request lost");

    // Terms of equal sign give that sign to the x result.
    a_same_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready && in_terms.xc.neg == in_terms.ys.neg) |=>
        (pt_reg.x_neg == $past(in_terms.xc.neg)))
        else $error("x result sign wrong");

endmodule

`default_nettype wire

// File: rtl/rotate_z_sign_magnitude.sv
// Top level of the Z-axis rotation of sign-magnitude points.
//
// Points arrive on the s_ stream channel and rotated points leave on the m_
// stream channel, one result request for every input request, in order.
// The angle is written on the cfg_ channel in steps of 5 degrees; values from
// 72 up are taken modulo 72. A write applies to every point that enters the
// product stage after the write is registered. A write must be made only
// while no point is in flight; the block itself does not enforce this. The
// pipeline has three register stages: input capture, the four Q10 products,
// and the sign-magnitude sums held in the output register, which a point
// passes in that order; one point can be accepted every cycle while m_tready
// does not stall. Each stage holds its contents while the stage after it is
// full and stalled, so a stall on m_tready fills empty stages first and only
// then drops s_tready; nothing is lost or repeated. Reset empties every stage
// and sets the angle to zero. The cfg_ channel is always ready.
`default_nettype none

module rotate_z_sign_magnitude (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // angle configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rzsm_pkg::AngleW-1:0]   cfg_data,
    // input points
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata, low bit up: x_mag[15:0], x_neg, y_mag[15:0], y_neg,
    // z_mag[15:0], z_neg, color[7:0], zero fill to 64 bits
    input  wire logic [rzsm_pkg::DataW-1:0]    s_tdata,
    // rotated points
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata, low bit up: rx_mag[15:0], rx_neg, ry_mag[15:0], ry_neg,
    // rz_mag[15:0], rz_neg, color_out[7:0], zero fill to 64 bits
    output logic [rzsm_pkg::DataW-1:0]         m_tdata
);
    import rzsm_pkg::*;

    localparam int unsigned PtW = 3 * (MagW + 1) + ColorW;

    rot_coef_t coef;
    logic      in_valid_reg;
    point_t    in_pt_reg;
    point_t    in_pt_next;
    logic      mult_in_ready;
    logic      mult_valid;
    logic      comb_in_ready;
    terms_t    mult_terms;
    point_t    out_pt;

    rzsm_coef u_coef (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    // Unpack the incoming request.
    always_comb begin
        in_pt_next.x_mag = s_tdata[15:0];
        in_pt_next.x_neg = s_tdata[16];
        in_pt_next.y_mag = s_tdata[32:17];
        in_pt_next.y_neg = s_tdata[33];
        in_pt_next.z_mag = s_tdata[49:34];
        in_pt_next.z_neg = s_tdata[50];
        in_pt_next.color = s_tdata[58:51];
    end

    assign s_tready = !in_valid_reg || mult_in_ready;

    // Input capture stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_pt_reg <= in_pt_next;
        end
    end

    rzsm_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .coef      (coef),
        .in_valid  (in_valid_reg),
        .in_ready  (mult_in_ready),
        .in_pt     (in_pt_reg),
        .out_valid (mult_valid),
        .out_ready (comb_in_ready),
        .out_terms (mult_terms)
    );

    rzsm_combine u_combine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mult_valid),
        .in_ready  (comb_in_ready),
        .in_terms  (mult_terms),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pt    (out_pt)
    );

    // Pack the result request.
    assign m_tdata = {
        (DataW - PtW)'(0),
        out_pt.color,
        out_pt.z_neg,
        out_pt.z_mag,
        out_pt.y_neg,
        out_pt.y_mag,
        out_pt.x_neg,
        out_pt.x_mag
    };

endmodule

`default_nettype wire
